FILE: rtl/core/ksc_pkg.sv
// Shared constants, codes and interface types for the keyword substitution cipher.
package ksc_pkg;

    localparam int ALPHABET_SIZE = 26;
    localparam int ADDR_W        = $clog2(ALPHABET_SIZE);
    localparam int COUNT_W       = $clog2(ALPHABET_SIZE + 1);

    localparam logic [7:0] LETTER_BASE = 8'd65;
    localparam logic [7:0] SPACE_CHAR  = 8'd32;

    typedef enum logic [2:0] {
        OP_CLEAR   = 3'd0,
        OP_SEED    = 3'd1,
        OP_FINISH  = 3'd2,
        OP_ENCRYPT = 3'd3,
        OP_DECRYPT = 3'd4
    } op_t;

    typedef enum logic [1:0] {
        STATUS_OK        = 2'd0,
        STATUS_BAD_CHAR  = 2'd1,
        STATUS_NOT_READY = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        SEL_ZERO    = 2'd0,
        SEL_SPACE   = 2'd1,
        SEL_FORWARD = 2'd2,
        SEL_INVERSE = 2'd3
    } sel_t;

    typedef enum logic [1:0] {
        ST_IDLE = 2'd0,
        ST_WALK = 2'd1,
        ST_DONE = 2'd2
    } state_t;

    typedef struct packed {
        logic accept;
        logic walk_step;
        logic finish;
        logic out_load;
    } cmd_t;

    typedef struct packed {
        logic need_walk;
        logic walk_last;
        logic out_free;
    } sts_t;

endpackage

FILE: rtl/core/ksc_ram.sv
// Generic single-write, single-read RAM with registered read data.
module ksc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

FILE: rtl/core/ksc_datapath.sv
// Datapath: key tables, used-letter flags, fill counter, walk counter and output register.
module ksc_datapath (
    input  logic          clk,
    input  logic          rst_n,
    input  ksc_pkg::cmd_t cmd,
    output ksc_pkg::sts_t sts,
    input  logic [2:0]    op,
    input  logic [7:0]    char_in,
    input  logic          out_ready,
    output logic          out_valid,
    output logic [7:0]    char_out,
    output logic [1:0]    status
);

    logic [ksc_pkg::ALPHABET_SIZE-1:0] used_reg, used_next;
    logic [ksc_pkg::COUNT_W-1:0]       fill_reg, fill_next;
    logic                              ready_reg, ready_next;
    logic [ksc_pkg::ADDR_W-1:0]        walk_reg, walk_next;
    ksc_pkg::sel_t                     sel_reg, sel_next;
    ksc_pkg::status_t                  acc_status_reg, acc_status_next;
    logic                              out_valid_reg, out_valid_next;
    logic [7:0]                        char_out_reg, char_out_next;
    logic [1:0]                        status_reg, status_next;

    logic                       is_letter;
    logic [ksc_pkg::ADDR_W-1:0] idx;
    logic                       seed_place;
    logic                       walk_place;
    logic                       need_walk;
    logic [7:0]                 char_diff;
    logic [ksc_pkg::ADDR_W-1:0] fwd_rdata, inv_rdata;
    logic [ksc_pkg::ADDR_W-1:0] fill_addr;
    logic [ksc_pkg::ADDR_W-1:0] inv_waddr;
    logic [ksc_pkg::ADDR_W-1:0] fwd_wdata;

    assign char_diff = char_in - ksc_pkg::LETTER_BASE;
    assign is_letter = ({1'b0, char_in} >= {1'b0, ksc_pkg::LETTER_BASE})
                    && ({1'b0, char_in} < ({1'b0, ksc_pkg::LETTER_BASE}
                                           + 9'(ksc_pkg::ALPHABET_SIZE)));
    assign idx       = char_diff[ksc_pkg::ADDR_W-1:0];
    assign fill_addr = fill_reg[ksc_pkg::ADDR_W-1:0];

    // Decode the accepted item: state updates for seeding and the result it will give.
    always_comb
    begin
        seed_place      = 1'b0;
        need_walk       = 1'b0;
        sel_next        = ksc_pkg::SEL_ZERO;
        acc_status_next = ksc_pkg::STATUS_OK;
        unique case (op)
            ksc_pkg::OP_CLEAR:
            begin
            end
            ksc_pkg::OP_SEED:
            begin
                if (!is_letter)
                begin
                    acc_status_next = ksc_pkg::STATUS_BAD_CHAR;
                end
                else
                begin
                    seed_place = !ready_reg && !used_reg[idx];
                end
            end
            ksc_pkg::OP_FINISH:
            begin
                need_walk = !ready_reg;
            end
            ksc_pkg::OP_ENCRYPT, ksc_pkg::OP_DECRYPT:
            begin
                if (!ready_reg)
                begin
                    acc_status_next = ksc_pkg::STATUS_NOT_READY;
                end
                else if (char_in == ksc_pkg::SPACE_CHAR)
                begin
                    sel_next = ksc_pkg::SEL_SPACE;
                end
                else if (!is_letter)
                begin
                    acc_status_next = ksc_pkg::STATUS_BAD_CHAR;
                end
                else if (op == ksc_pkg::OP_ENCRYPT)
                begin
                    sel_next = ksc_pkg::SEL_FORWARD;
                end
                else
                begin
                    sel_next = ksc_pkg::SEL_INVERSE;
                end
            end
            default:
            begin
            end
        endcase
    end

    assign walk_place = cmd.walk_step && !used_reg[walk_reg];
    assign inv_waddr  = cmd.walk_step ? walk_reg : idx;
    assign fwd_wdata  = cmd.walk_step ? walk_reg : idx;

    ksc_ram #(
        .WIDTH (ksc_pkg::ADDR_W),
        .DEPTH (ksc_pkg::ALPHABET_SIZE)
    ) u_forward (
        .clk   (clk),
        .we    ((cmd.accept && seed_place) || walk_place),
        .waddr (fill_addr),
        .wdata (fwd_wdata),
        .re    (cmd.accept),
        .raddr (idx),
        .rdata (fwd_rdata)
    );

    ksc_ram #(
        .WIDTH (ksc_pkg::ADDR_W),
        .DEPTH (ksc_pkg::ALPHABET_SIZE)
    ) u_inverse (
        .clk   (clk),
        .we    ((cmd.accept && seed_place) || walk_place),
        .waddr (inv_waddr),
        .wdata (fill_addr),
        .re    (cmd.accept),
        .raddr (idx),
        .rdata (inv_rdata)
    );

    always_comb
    begin
        used_next      = used_reg;
        fill_next      = fill_reg;
        ready_next     = ready_reg;
        walk_next      = walk_reg;
        out_valid_next = out_valid_reg;
        char_out_next  = char_out_reg;
        status_next    = status_reg;

        if (cmd.accept)
        begin
            walk_next = '0;
            if (op == ksc_pkg::OP_CLEAR)
            begin
                used_next  = '0;
                fill_next  = '0;
                ready_next = 1'b0;
            end
            else if (seed_place)
            begin
                used_next[idx] = 1'b1;
                fill_next      = fill_reg + 1'b1;
            end
        end

        if (cmd.walk_step)
        begin
            walk_next = walk_reg + 1'b1;
            if (walk_place)
            begin
                used_next[walk_reg] = 1'b1;
                fill_next           = fill_reg + 1'b1;
            end
        end

        if (cmd.finish)
        begin
            ready_next = 1'b1;
        end

        if (cmd.out_load)
        begin
            out_valid_next = 1'b1;
            status_next    = acc_status_reg;
            case (sel_reg)
                ksc_pkg::SEL_SPACE:   char_out_next = ksc_pkg::SPACE_CHAR;
                ksc_pkg::SEL_FORWARD: char_out_next = ksc_pkg::LETTER_BASE + 8'(fwd_rdata);
                ksc_pkg::SEL_INVERSE: char_out_next = ksc_pkg::LETTER_BASE + 8'(inv_rdata);
                default:              char_out_next = 8'd0;
            endcase
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            used_reg      <= '0;
            fill_reg      <= '0;
            ready_reg     <= 1'b0;
            walk_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            used_reg      <= used_next;
            fill_reg      <= fill_next;
            ready_reg     <= ready_next;
            walk_reg      <= walk_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            sel_reg        <= sel_next;
            acc_status_reg <= acc_status_next;
        end
        char_out_reg <= char_out_next;
        status_reg   <= status_next;
    end

    assign sts.need_walk = need_walk;
    assign sts.walk_last = (walk_reg == ksc_pkg::ADDR_W'(ksc_pkg::ALPHABET_SIZE - 1));
    assign sts.out_free  = !out_valid_reg || out_ready;

    assign out_valid = out_valid_reg;
    assign char_out  = char_out_reg;
    assign status    = status_reg;

`ifndef SYNTHESIS
    a_fill_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= ksc_pkg::COUNT_W'(ksc_pkg::ALPHABET_SIZE))
        else $error("fill counter ran past the alphabet");

    a_error_zero_char: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && (status_reg != ksc_pkg::STATUS_OK) |-> char_out_reg == 8'd0)
        else $error("error result carries a non-zero character");

    a_finish_fills_key: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.finish |=> fill_reg == ksc_pkg::COUNT_W'(ksc_pkg::ALPHABET_SIZE))
        else $error("key not complete after the finishing walk");
`endif

endmodule

FILE: rtl/core/ksc_ctrl.sv
// Controller state machine: input handshake, key-completion walk and result hand-off.
module ksc_ctrl (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_ready,
    input  ksc_pkg::sts_t sts,
    output ksc_pkg::cmd_t cmd
);

    ksc_pkg::state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ksc_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        in_ready   = 1'b0;
        cmd        = '0;
        unique case (state_reg)
            ksc_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.accept = 1'b1;
                    state_next = sts.need_walk ? ksc_pkg::ST_WALK : ksc_pkg::ST_DONE;
                end
            end
            ksc_pkg::ST_WALK:
            begin
                cmd.walk_step = 1'b1;
                if (sts.walk_last)
                begin
                    cmd.finish = 1'b1;
                    state_next = ksc_pkg::ST_DONE;
                end
            end
            ksc_pkg::ST_DONE:
            begin
                // The result waits here until the output register can take it.
                if (sts.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = ksc_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = ksc_pkg::ST_IDLE;
            end
        endcase
    end

`ifndef SYNTHESIS
    a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ksc_pkg::ST_IDLE) && in_valid |=> state_reg != ksc_pkg::ST_IDLE)
        else $error("transfer accepted but controller stayed idle");

    a_walk_ends: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ksc_pkg::ST_WALK) && sts.walk_last |=> state_reg == ksc_pkg::ST_DONE)
        else $error("walk did not end after the last letter");

    a_result_handed: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ksc_pkg::ST_DONE) && sts.out_free |=> state_reg == ksc_pkg::ST_IDLE)
        else $error("result not handed to the output register");
`endif

endmodule

FILE: rtl/core/keyword_substitution_cipher_unit.sv
// Keyword substitution cipher unit: accepts one transfer of op and
// character at a time and returns exactly one result transfer for it.
// An item passes through the controller states IDLE, in which the input transfer
// is taken, the op is decoded and the key tables are read, and DONE, which loads
// the output register. The result is valid from the cycle after that, and the
// next item may be taken while it still waits to be collected. A finish op on
// an unfinished key walks the alphabet one letter per cycle in WALK between the
// two. While an earlier result has not been collected, the load waits and no
// new input transfer is taken. Status is 0 for ok, 1 for a character that is
// not a letter (for encrypt and decrypt, not a letter or space), and 2 for
// encrypt or decrypt before the key is finished; char_out is zero unless a
// character is returned.
module keyword_substitution_cipher_unit (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [2:0] op,
    input  logic [7:0] char_in,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [7:0] char_out,
    output logic [1:0] status
);

    ksc_pkg::cmd_t cmd;
    ksc_pkg::sts_t sts;

    ksc_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .sts       (sts),
        .op        (op),
        .char_in   (char_in),
        .out_ready (out_ready),
        .out_valid (out_valid),
        .char_out  (char_out),
        .status    (status)
    );

    ksc_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .sts      (sts),
        .cmd      (cmd)
    );

endmodule

FILE: dv/keyword_substitution_cipher_unit_tb.sv
// Self-checking testbench for the keyword substitution cipher unit.
`timescale 1ns / 100ps

module keyword_substitution_cipher_unit_tb;

    typedef struct {
        logic [7:0] ch;
        logic [1:0] st;
    } cipher_result_t;

    // Tracks the keyed alphabet as the block should build it and holds the
    // results still due, oldest first.
    class cipher_tracker;
        logic [ksc_pkg::ADDR_W-1:0]        fwd_key [ksc_pkg::ALPHABET_SIZE];
        logic [ksc_pkg::ADDR_W-1:0]        inv_key [ksc_pkg::ALPHABET_SIZE];
        logic [ksc_pkg::ALPHABET_SIZE-1:0] seen_letters;
        int                                key_len;
        bit                                key_done;
        cipher_result_t                    due_results [$];
        int                                errors;

        function new();
            seen_letters = '0;
            key_len      = 0;
            key_done     = 1'b0;
            errors       = 0;
        endfunction

        task report_mismatch(string msg);
            $display("%0t ns: mismatch: %s", $time, msg);
            errors++;
        endtask

        function int pending();
            return due_results.size();
        endfunction

        function void add_letter(logic [ksc_pkg::ADDR_W-1:0] idx);
            if (key_len < ksc_pkg::ALPHABET_SIZE)
            begin
                fwd_key[key_len]  = idx;
                inv_key[idx]      = ksc_pkg::ADDR_W'(key_len);
                seen_letters[idx] = 1'b1;
                key_len++;
            end
        endfunction

        function void take_item(logic [2:0] code, logic [7:0] c);
            cipher_result_t             res;
            logic                       is_letter;
            logic [ksc_pkg::ADDR_W-1:0] idx;
            res.ch    = '0;
            res.st    = ksc_pkg::STATUS_OK;
            is_letter = (c >= ksc_pkg::LETTER_BASE)
                     && (c < ksc_pkg::LETTER_BASE + 8'(ksc_pkg::ALPHABET_SIZE));
            idx       = ksc_pkg::ADDR_W'(c - ksc_pkg::LETTER_BASE);
            case (code)
                ksc_pkg::OP_CLEAR:
                begin
                    seen_letters = '0;
                    key_len      = 0;
                    key_done     = 1'b0;
                end
                ksc_pkg::OP_SEED:
                begin
                    if (!is_letter)
                        res.st = ksc_pkg::STATUS_BAD_CHAR;
                    else if (!key_done && !seen_letters[idx])
                        add_letter(idx);
                end
                ksc_pkg::OP_FINISH:
                begin
                    if (!key_done)
                    begin
                        for (int i = 0; i < ksc_pkg::ALPHABET_SIZE; i++)
                            if (!seen_letters[i])
                                add_letter(ksc_pkg::ADDR_W'(i));
                        key_done = 1'b1;
                    end
                end
                ksc_pkg::OP_ENCRYPT, ksc_pkg::OP_DECRYPT:
                begin
                    // The readiness check takes precedence over the character check.
                    if (!key_done)
                        res.st = ksc_pkg::STATUS_NOT_READY;
                    else if (c == ksc_pkg::SPACE_CHAR)
                        res.ch = ksc_pkg::SPACE_CHAR;
                    else if (!is_letter)
                        res.st = ksc_pkg::STATUS_BAD_CHAR;
                    else if (code == ksc_pkg::OP_ENCRYPT)
                        res.ch = ksc_pkg::LETTER_BASE + 8'(fwd_key[idx]);
                    else
                        res.ch = ksc_pkg::LETTER_BASE + 8'(inv_key[idx]);
                end
                default: ;
            endcase
            due_results.push_back(res);
        endfunction

        task match_result(logic [7:0] ch, logic [1:0] st);
            cipher_result_t res;
            if (due_results.size() == 0)
            begin
                report_mismatch($sformatf("result char %h status %0d with none due", ch, st));
            end
            else
            begin
                res = due_results.pop_front();
                if (ch !== res.ch)
                    report_mismatch($sformatf("char_out %h, want %h", ch, res.ch));
                if (st !== res.st)
                    report_mismatch($sformatf("status %0d, want %0d", st, res.st));
            end
        endtask
    endclass

    logic       clk       = 1'b0;
    logic       rst_n     = 1'b0;
    logic       in_valid  = 1'b0;
    logic       in_ready;
    logic [2:0] op        = '0;
    logic [7:0] char_in   = '0;
    logic       out_valid;
    logic       out_ready = 1'b0;
    logic [7:0] char_out;
    logic [1:0] status;

    cipher_tracker book = new();
    int            items_sent = 0;
    bit            calm = 1'b0;
    bit            sender_idles = 1'b1;

    keyword_substitution_cipher_unit i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .op        (op),
        .char_in   (char_in),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .char_out  (char_out),
        .status    (status)
    );

    always #5 clk = ~clk;

    // Inputs only change at rising edges, so the falling edge sees settled values.
    always @(negedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            book.match_result(char_out, status);
    end

    initial
    begin
        wait (rst_n);
        @(posedge clk);
        forever
        begin
            if (!calm && $urandom_range(0, 2) == 0)
            begin
                out_ready <= 1'b0;
                repeat ($urandom_range(1, 17)) @(posedge clk);
            end
            out_ready <= 1'b1;
            repeat ($urandom_range(1, 30)) @(posedge clk);
        end
    end

    // Starts and ends just after rising edges; ends at or after the transfer edge.
    task send_item(logic [2:0] code, logic [7:0] c);
        in_valid <= 1'b1;
        op       <= code;
        char_in  <= c;
        @(negedge clk);
        while (!in_ready) @(negedge clk);
        book.take_item(code, c);
        @(posedge clk);
        items_sent++;
        if (!calm && sender_idles && $urandom_range(0, 5) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge clk);
        end
    endtask

    task wait_for_results();
        in_valid <= 1'b0;
        @(posedge clk);
        while (book.pending() != 0) @(posedge clk);
    endtask

    function logic [7:0] any_letter();
        return ksc_pkg::LETTER_BASE + 8'($urandom_range(0, ksc_pkg::ALPHABET_SIZE - 1));
    endfunction

    function logic [7:0] mostly_letter();
        int pick;
        pick = $urandom_range(0, 19);
        if (pick < 16)
            return any_letter();
        else if (pick < 18)
            return ksc_pkg::SPACE_CHAR;
        else
            return 8'($urandom_range(0, 255));
    endfunction

    // One pass of building a key and using it, with the occasional slip.
    task run_key_session();
        int         n_seed;
        int         n_use;
        int         j;
        logic [7:0] perm [ksc_pkg::ALPHABET_SIZE];
        logic [7:0] tmp;
        logic [7:0] seed_char;
        logic [2:0] code;
        sender_idles = ($urandom_range(0, 2) != 0);
        if ($urandom_range(0, 9) != 0)
            send_item(ksc_pkg::OP_CLEAR, 8'($urandom_range(0, 255)));
        if ($urandom_range(0, 7) == 0)
        begin
            // Seed the whole alphabet in a shuffled order, so finish adds nothing.
            for (int i = 0; i < ksc_pkg::ALPHABET_SIZE; i++)
                perm[i] = ksc_pkg::LETTER_BASE + 8'(i);
            for (int i = ksc_pkg::ALPHABET_SIZE - 1; i > 0; i--)
            begin
                j       = $urandom_range(0, i);
                tmp     = perm[i];
                perm[i] = perm[j];
                perm[j] = tmp;
            end
            for (int i = 0; i < ksc_pkg::ALPHABET_SIZE; i++)
                send_item(ksc_pkg::OP_SEED, perm[i]);
        end
        else
        begin
            n_seed = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 40)
                                                 : $urandom_range(0, 10);
            for (int i = 0; i < n_seed; i++)
            begin
                seed_char = ($urandom_range(0, 9) == 0) ? 8'($urandom_range(0, 255))
                                                        : any_letter();
                send_item(ksc_pkg::OP_SEED, seed_char);
            end
        end
        if ($urandom_range(0, 9) == 0)
            send_item(ksc_pkg::OP_ENCRYPT, any_letter());
        if ($urandom_range(0, 15) != 0)
            send_item(ksc_pkg::OP_FINISH, 8'($urandom_range(0, 255)));
        n_use = $urandom_range(4, 30);
        for (int i = 0; i < n_use; i++)
        begin
            if ($urandom_range(0, 19) == 0)
            begin
                code = 3'($urandom_range(0, 7));
                send_item(code, 8'($urandom_range(0, 255)));
            end
            else
            begin
                code = ($urandom_range(0, 1) == 0) ? ksc_pkg::OP_ENCRYPT : ksc_pkg::OP_DECRYPT;
                send_item(code, mostly_letter());
            end
        end
    endtask

    initial
    begin
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part: use before the key exists, seed corner characters,
        // double finish, late seed, both directions at the alphabet ends,
        // space, bad characters and the unused op codes.
        send_item(ksc_pkg::OP_ENCRYPT, ksc_pkg::LETTER_BASE);
        send_item(ksc_pkg::OP_DECRYPT, ksc_pkg::SPACE_CHAR);
        send_item(ksc_pkg::OP_CLEAR, 8'hFF);
        send_item(ksc_pkg::OP_SEED, ksc_pkg::LETTER_BASE + 8'(ksc_pkg::ALPHABET_SIZE - 1));
        send_item(ksc_pkg::OP_SEED, ksc_pkg::LETTER_BASE);
        send_item(ksc_pkg::OP_SEED, ksc_pkg::LETTER_BASE + 8'(ksc_pkg::ALPHABET_SIZE - 1));
        send_item(ksc_pkg::OP_SEED, ksc_pkg::SPACE_CHAR);
        send_item(ksc_pkg::OP_SEED, 8'hFF);
        send_item(ksc_pkg::OP_SEED, ksc_pkg::LETTER_BASE - 8'd1);
        send_item(ksc_pkg::OP_SEED, ksc_pkg::LETTER_BASE + 8'(ksc_pkg::ALPHABET_SIZE));
        send_item(ksc_pkg::OP_FINISH, 8'h00);
        send_item(ksc_pkg::OP_FINISH, 8'hAA);
        send_item(ksc_pkg::OP_SEED, ksc_pkg::LETTER_BASE + 8'd16);
        send_item(ksc_pkg::OP_ENCRYPT, ksc_pkg::LETTER_BASE);
        send_item(ksc_pkg::OP_ENCRYPT, ksc_pkg::LETTER_BASE + 8'(ksc_pkg::ALPHABET_SIZE - 1));
        send_item(ksc_pkg::OP_DECRYPT, ksc_pkg::LETTER_BASE);
        send_item(ksc_pkg::OP_DECRYPT, ksc_pkg::LETTER_BASE + 8'(ksc_pkg::ALPHABET_SIZE - 1));
        send_item(ksc_pkg::OP_ENCRYPT, ksc_pkg::SPACE_CHAR);
        send_item(ksc_pkg::OP_DECRYPT, ksc_pkg::SPACE_CHAR);
        send_item(ksc_pkg::OP_ENCRYPT, 8'h61);
        send_item(ksc_pkg::OP_DECRYPT, 8'h00);
        send_item(ksc_pkg::OP_ENCRYPT, 8'h80);
        send_item(3'd5, 8'hFF);
        send_item(3'd6, ksc_pkg::LETTER_BASE);
        send_item(3'd7, 8'h55);
        wait_for_results();

        while (items_sent < 1600)
        begin
            if (items_sent >= 1450)
                calm = 1'b1;
            run_key_session();
            if (!calm && $urandom_range(0, 11) == 0)
                wait_for_results();
        end

        wait_for_results();
        repeat (40) @(posedge clk);
        if (book.pending() != 0)
            book.report_mismatch($sformatf("%0d results never arrived", book.pending()));
        if (book.errors == 0)
            $display("keyword_substitution_cipher_unit_tb: clean");
        else
            $display("keyword_substitution_cipher_unit_tb: errors");
        $finish;
    end

    initial
    begin
        #5_000_000;
        $display("keyword_substitution_cipher_unit_tb: errors");
        $finish;
    end

endmodule

FILE: files.f
rtl/core/ksc_pkg.sv
rtl/core/ksc_ram.sv
rtl/core/ksc_datapath.sv
rtl/core/ksc_ctrl.sv
rtl/core/keyword_substitution_cipher_unit.sv
dv/keyword_substitution_cipher_unit_tb.sv
